// File: design/cbq_pkg.sv
// Shared types, constants and arithmetic helpers for the cascaded biquad filter.
// Used by the section cell, the top level and the port checker. No dependencies.
`timescale 1ns / 1ps

package cbq_pkg;

  localparam int MAX_STAGES      = 4;
  localparam int SAMPLE_BITS     = 24;
  localparam int COEF_BITS       = 32;
  localparam int COEF_FRAC       = 30;
  localparam int STATE_FRAC      = 20;
  localparam int STATE_BITS      = 48;
  localparam int COEFS_PER_STAGE = 5;

  localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
  localparam int SHIFT       = COEF_FRAC - STATE_FRAC;
  localparam int SCALED_BITS = PROD_BITS + 1 - SHIFT;
  localparam int WIDE_BITS   = STATE_BITS + 2;
  localparam int ROUND_ADD   = 1 << (SHIFT - 1);
  localparam int HALF_LSB    = 1 << (STATE_FRAC - 1);
  localparam int YQ_BITS     = STATE_BITS + 1 - STATE_FRAC;

  // configuration port
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 4;
  localparam int NSTG_BITS = 3;
  localparam int CIDX_BITS = 5;
  localparam int CSEL_BITS = 3;

  localparam logic [1:0] REG_NUM_STAGES = 2'd0;
  localparam logic [1:0] REG_COEF_INDEX = 2'd1;
  localparam logic [1:0] REG_COEF_VALUE = 2'd2;

  // coefficient order within a section
  localparam logic [CSEL_BITS-1:0] C_B0 = 3'd0;
  localparam logic [CSEL_BITS-1:0] C_B1 = 3'd1;
  localparam logic [CSEL_BITS-1:0] C_B2 = 3'd2;
  localparam logic [CSEL_BITS-1:0] C_A1 = 3'd3;
  localparam logic [CSEL_BITS-1:0] C_A2 = 3'd4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SCALED_BITS-1:0] scaled_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;

  typedef struct packed {
    logic    eob;
    sample_t x;
  } smp_t;

  typedef struct packed {
    logic                 en;
    logic [CSEL_BITS-1:0] sel;
    coef_t                value;
  } coef_wr_t;

  function automatic prod_t mul(input coef_t c, input sample_t x);
    return PROD_BITS'(c) * PROD_BITS'(x);
  endfunction

  // product to state format, round half up
  function automatic scaled_t scale_prod(input prod_t p);
    logic signed [PROD_BITS:0] t;
    t = (PROD_BITS + 1)'(p) + (PROD_BITS + 1)'(ROUND_ADD);
    return t[PROD_BITS:SHIFT];
  endfunction

  function automatic state_t sat_state(input wide_t v);
    if (v[WIDE_BITS-1:STATE_BITS-1] == '0 || v[WIDE_BITS-1:STATE_BITS-1] == '1) begin
      return v[STATE_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      return {1'b1, {(STATE_BITS - 1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_BITS - 1){1'b1}}};
    end
  endfunction

  function automatic sample_t sat_sample(input logic signed [YQ_BITS-1:0] v);
    if (v[YQ_BITS-1:SAMPLE_BITS-1] == '0 || v[YQ_BITS-1:SAMPLE_BITS-1] == '1) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[YQ_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  endfunction

  // state-format y to a saturated sample
  function automatic sample_t round_sample(input state_t y);
    logic signed [STATE_BITS:0] t;
    t = (STATE_BITS + 1)'(y) + (STATE_BITS + 1)'(HALF_LSB);
    return sat_sample(t[STATE_BITS:STATE_FRAC]);
  endfunction

endpackage

// File: design/cbq_cell.sv
// One second-order section of the cascade: its five coefficients, its two states,
// a four-step multiply/update sequence and an output hold register. Uses cbq_pkg.
`timescale 1ns / 1ps

module cbq_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable,
  input  cbq_pkg::coef_wr_t cw,
  input  logic              up_valid,
  input  cbq_pkg::smp_t     up_smp,
  output logic              up_ready,
  output logic              dn_valid,
  output cbq_pkg::smp_t     dn_smp,
  input  logic              dn_ready
);
  import cbq_pkg::*;

  localparam logic [1:0] PH_MULX = 2'd0;
  localparam logic [1:0] PH_Y    = 2'd1;
  localparam logic [1:0] PH_MULY = 2'd2;
  localparam logic [1:0] PH_UPD  = 2'd3;

  coef_t   b0, b1, b2, a1, a2;
  state_t  s1, s2;
  state_t  s1_next, s2_next;
  logic    busy;
  logic [1:0] phase;
  sample_t x_r;
  logic    eob_r;
  prod_t   pb0, pb1, pb2, pa1, pa2;
  scaled_t sb1, sb2;
  sample_t yq, yq_next;
  state_t  y;
  logic    finish, take;

  assign finish   = busy && (phase == PH_UPD) && (!dn_valid || dn_ready);
  assign up_ready = !busy || finish;
  assign take     = up_valid && up_ready;

  assign y       = sat_state(WIDE_BITS'(scale_prod(pb0)) + WIDE_BITS'(s1));
  assign yq_next = round_sample(y);
  assign s1_next = sat_state(WIDE_BITS'(sb1) - WIDE_BITS'(scale_prod(pa1)) + WIDE_BITS'(s2));
  assign s2_next = sat_state(WIDE_BITS'(sb2) - WIDE_BITS'(scale_prod(pa2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      phase    <= PH_MULX;
      dn_valid <= 1'b0;
      s1       <= '0;
      s2       <= '0;
    end else begin
      if (dn_valid && dn_ready) begin
        dn_valid <= 1'b0;
      end
      if (finish) begin
        dn_valid <= 1'b1;
        busy     <= 1'b0;
        if (enable) begin
          s1 <= s1_next;
          s2 <= s2_next;
        end
      end
      if (take) begin
        busy  <= 1'b1;
        phase <= PH_MULX;
      end else if (busy && phase != PH_UPD) begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.en) begin
      case (cw.sel)
        C_B0: b0 <= cw.value;
        C_B1: b1 <= cw.value;
        C_B2: b2 <= cw.value;
        C_A1: a1 <= cw.value;
        C_A2: a2 <= cw.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r   <= up_smp.x;
      eob_r <= up_smp.eob;
    end
    if (busy) begin
      case (phase)
        PH_MULX: begin
          pb0 <= mul(b0, x_r);
          pb1 <= mul(b1, x_r);
          pb2 <= mul(b2, x_r);
        end
        PH_Y: begin
          yq  <= yq_next;
          sb1 <= scale_prod(pb1);
          sb2 <= scale_prod(pb2);
        end
        PH_MULY: begin
          pa1 <= mul(a1, yq);
          pa2 <= mul(a2, yq);
        end
        default: ;
      endcase
    end
    // a section past the active count passes the sample through untouched
    if (finish) begin
      dn_smp.x   <= enable ? yq : x_r;
      dn_smp.eob <= eob_r;
    end
  end

endmodule

// File: design/cascaded_biquad_iir_filter.sv
// Cascaded biquad IIR filter: top level with the configuration port and the chain
// of section cells. Depends on cbq_pkg and cbq_cell.
// Each cell runs a multiply, round, feedback multiply and state update sequence on its
// item and takes the next item as it finishes the last; cells work on successive items.
// Reset (rst, synchronous): states and handshake clear, num_stages reads 1;
// coefficients hold no value until written.
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbq_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [cbq_pkg::DATA_BITS-1:0]       pwdata,
  output logic [cbq_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cbq_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                end_of_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cbq_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                end_of_block_out
);
  import cbq_pkg::*;

  logic [NSTG_BITS-1:0] num_stages;
  logic [CIDX_BITS-1:0] coef_index;
  coef_t                coef_value;
  logic                 wr;
  logic [1:0]           reg_sel;

  logic     link_valid [MAX_STAGES+1];
  logic     link_ready [MAX_STAGES+1];
  smp_t     link_smp   [MAX_STAGES+1];
  coef_wr_t cw         [MAX_STAGES];

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stages <= NSTG_BITS'(1);
      coef_index <= '0;
      coef_value <= '0;
    end else if (wr) begin
      case (reg_sel)
        REG_NUM_STAGES: num_stages <= pwdata[NSTG_BITS-1:0];
        REG_COEF_INDEX: coef_index <= pwdata[CIDX_BITS-1:0];
        REG_COEF_VALUE: coef_value <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NUM_STAGES: prdata = DATA_BITS'(num_stages);
      REG_COEF_INDEX: prdata = DATA_BITS'(coef_index);
      REG_COEF_VALUE: prdata = coef_value;
      default:        prdata = '0;
    endcase
  end

  assign link_valid[0]   = in_valid;
  assign link_smp[0].x   = in_sample;
  assign link_smp[0].eob = end_of_block;
  assign in_ready        = link_ready[0];

  assign out_valid                = link_valid[MAX_STAGES];
  assign out_sample               = link_smp[MAX_STAGES].x;
  assign end_of_block_out         = link_smp[MAX_STAGES].eob;
  assign link_ready[MAX_STAGES]   = out_ready;

  for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
    // route a table write to the section that owns the entry
    assign cw[k].en    = wr && (reg_sel == REG_COEF_VALUE)
                         && (32'(coef_index) >= COEFS_PER_STAGE * k)
                         && (32'(coef_index) < COEFS_PER_STAGE * (k + 1));
    assign cw[k].sel   = CSEL_BITS'(32'(coef_index) - 32'(COEFS_PER_STAGE * k));
    assign cw[k].value = pwdata;

    cbq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .enable   (32'(num_stages) > k),
      .cw       (cw[k]),
      .up_valid (link_valid[k]),
      .up_smp   (link_smp[k]),
      .up_ready (link_ready[k]),
      .dn_valid (link_valid[k+1]),
      .dn_smp   (link_smp[k+1]),
      .dn_ready (link_ready[k+1])
    );
  end

endmodule

// File: design/cbq_checker.sv
// Port-level checks for the cascaded biquad filter, bound to the top level.
// Depends on cbq_pkg.
`timescale 1ns / 1ps

module cbq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [cbq_pkg::ADDR_BITS-1:0]       paddr,
  input logic [cbq_pkg::DATA_BITS-1:0]       pwdata,
  input logic [cbq_pkg::DATA_BITS-1:0]       prdata,
  input logic                                pready,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [cbq_pkg::SAMPLE_BITS-1:0] out_sample,
  input logic                                end_of_block_out
);
  import cbq_pkg::*;

  localparam int CNT_BITS = $clog2(2 * MAX_STAGES + 2) + 1;

  logic [CNT_BITS-1:0] inflight;
  logic                in_acc, out_acc, wr_coef;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign wr_coef = psel && penable && pwrite && pready
                   && (paddr[ADDR_BITS-1:2] == REG_COEF_VALUE);

  // count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + CNT_BITS'(1);
    end else if (out_acc && !in_acc) begin
      inflight <= inflight - CNT_BITS'(1);
    end
  end

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> inflight != '0)
    else $error("result delivered with no item in flight");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> !out_valid)
    else $error("out_valid raised while no item is in flight");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_BITS'(2 * MAX_STAGES))
    else $error("more items in flight than the cell chain can hold");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample)
                                && $stable(end_of_block_out))
    else $error("stalled result changed or dropped");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    wr_coef ##1 (paddr[ADDR_BITS-1:2] == REG_COEF_VALUE) |-> prdata == $past(pwdata))
    else $error("coefficient value register does not read back");

endmodule

bind cascaded_biquad_iir_filter cbq_checker u_cbq_checker (.*);

// File: verif/tb_cascaded_biquad_iir_filter.sv
// Self-checking testbench for cascaded_biquad_iir_filter: a directed table, then random
// reconfiguration phases with bursty input and a stalling output side.
// Depends on cbq_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_cascaded_biquad_iir_filter;
  import cbq_pkg::*;

  localparam int NUM_COEFS  = MAX_STAGES * COEFS_PER_STAGE;
  localparam int RAND_ITEMS = 1730;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam coef_t Q_ONE = 32'sh4000_0000;
  localparam coef_t Q_MIN = 32'sh8000_0000;
  localparam coef_t Q_MAX = 32'sh7FFF_FFFF;
  localparam longint UNITY  = 64'sd1073741824;
  localparam longint A2_LIM = 64'sd966367641;

  // second-order lowpass near a tenth of the sample rate
  localparam coef_t LP_B0 = 32'sd72477573;
  localparam coef_t LP_B1 = 32'sd144955146;
  localparam coef_t LP_A1 = -32'sd1227286905;
  localparam coef_t LP_A2 = 32'sd443240625;

  localparam sample_t S_MAX = 24'sh7F_FFFF;
  localparam sample_t S_MIN = 24'sh80_0000;

  typedef enum logic [2:0] {
    SET_UNITY, SET_NEG2, SET_LOWPASS, SET_STABLE, SET_WILD
  } coef_set_e;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_e;

  typedef struct packed {
    coef_set_e  cset;
    logic [2:0] stages;
    sample_t    smp;
    logic       eob;
    logic       known;
    sample_t    want;
  } dir_row_t;

  typedef struct {
    sample_t smp;
    logic    eob;
  } filtered_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // unity sections: every stage passes the sample through
    '{SET_UNITY,   3'd4, 24'sd0,       1'b0, 1'b1, 24'sd0},
    '{SET_UNITY,   3'd4, S_MAX,        1'b1, 1'b1, S_MAX},
    '{SET_UNITY,   3'd4, S_MIN,        1'b0, 1'b1, S_MIN},
    '{SET_UNITY,   3'd4, 24'sd1,       1'b0, 1'b1, 24'sd1},
    '{SET_UNITY,   3'd4, -24'sd1,      1'b0, 1'b1, -24'sd1},
    '{SET_UNITY,   3'd4, 24'sh55_5555, 1'b0, 1'b1, 24'sh55_5555},
    '{SET_UNITY,   3'd4, 24'shAA_AAAA, 1'b1, 1'b1, 24'shAA_AAAA},
    // gain of -2.0 saturates at both ends
    '{SET_NEG2,    3'd1, S_MIN,        1'b0, 1'b1, S_MAX},
    '{SET_NEG2,    3'd1, S_MAX,        1'b0, 1'b1, S_MIN},
    '{SET_NEG2,    3'd1, 24'sd1,       1'b0, 1'b1, -24'sd2},
    '{SET_NEG2,    3'd1, -24'sd1,      1'b1, 1'b1, 24'sd2},
    '{SET_NEG2,    3'd1, 24'sd0,       1'b0, 1'b1, 24'sd0},
    // zero stages bypass the cascade
    '{SET_LOWPASS, 3'd0, S_MAX,        1'b0, 1'b1, S_MAX},
    '{SET_LOWPASS, 3'd0, S_MIN,        1'b1, 1'b1, S_MIN},
    '{SET_LOWPASS, 3'd0, 24'sd4660,    1'b0, 1'b1, 24'sd4660},
    // stage count above the maximum acts as the maximum; the last rows lower the stage count again
    '{SET_LOWPASS, 3'd7, S_MAX,        1'b0, 1'b0, 24'sd0},
    '{SET_LOWPASS, 3'd7, 24'sd0,       1'b0, 1'b0, 24'sd0},
    '{SET_LOWPASS, 3'd7, 24'sd0,       1'b0, 1'b0, 24'sd0},
    '{SET_LOWPASS, 3'd7, 24'sd0,       1'b0, 1'b0, 24'sd0},
    '{SET_LOWPASS, 3'd7, S_MIN,        1'b1, 1'b0, 24'sd0},
    '{SET_LOWPASS, 3'd2, 24'sd1000,    1'b0, 1'b0, 24'sd0},
    '{SET_LOWPASS, 3'd2, 24'sd1000,    1'b0, 1'b0, 24'sd0},
    '{SET_LOWPASS, 3'd2, 24'sd1000,    1'b1, 1'b0, 24'sd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  sample_t in_sample;
  logic end_of_block;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_sample;
  logic end_of_block_out;

  // register mirror and section states
  logic [NSTG_BITS-1:0] cfg_stages = 3'd1;
  logic [CIDX_BITS-1:0] cfg_index  = '0;
  logic [DATA_BITS-1:0] cfg_value  = '0;
  coef_t  coef_mem [NUM_COEFS]  = '{default: '0};
  longint sec_s1   [MAX_STAGES] = '{default: 0};
  longint sec_s2   [MAX_STAGES] = '{default: 0};

  filtered_t out_expect [$];
  int err_count  = 0;
  int burst_left = 20;

  rx_mode_e rx_mode = RX_OPEN;
  int rx_left = 0;
  int rx_tick = 0;

  always #4 clk = ~clk;

  cascaded_biquad_iir_filter dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .end_of_block(end_of_block),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample),
    .end_of_block_out(end_of_block_out)
  );

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // coefficient times value, rounded half up into state format
  function automatic longint scaled(input coef_t c, input longint v);
    return (longint'(c) * v + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
  endfunction

  function automatic sample_t filter_sample(input sample_t x_in);
    longint x, y, yq, n1, n2;
    int n, base;
    x = x_in;
    n = (cfg_stages > MAX_STAGES) ? MAX_STAGES : int'(cfg_stages);
    for (int k = 0; k < n; k++) begin
      base = k * COEFS_PER_STAGE;
      y  = clamp(scaled(coef_mem[base + C_B0], x) + sec_s1[k], STATE_BITS);
      yq = clamp((y + (longint'(1) <<< (STATE_FRAC - 1))) >>> STATE_FRAC, SAMPLE_BITS);
      n1 = scaled(coef_mem[base + C_B1], x) - scaled(coef_mem[base + C_A1], yq) + sec_s2[k];
      n2 = scaled(coef_mem[base + C_B2], x) - scaled(coef_mem[base + C_A2], yq);
      sec_s1[k] = clamp(n1, STATE_BITS);
      sec_s2[k] = clamp(n2, STATE_BITS);
      x = yq;
    end
    return sample_t'(x);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5:       return sample_t'(int'($urandom_range(0, 4000)) - 2000);
      6:          return $urandom_range(0, 1) ? S_MAX : S_MIN;
      7:          return sample_t'(24'd1 << $urandom_range(0, 23));
      8:          return '0;
      default:    return sample_t'(int'($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_BITS-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NUM_STAGES: cfg_stages = data[NSTG_BITS-1:0];
      REG_COEF_INDEX: cfg_index = data[CIDX_BITS-1:0];
      REG_COEF_VALUE: begin
        cfg_value = data;
        if (cfg_index < NUM_COEFS) coef_mem[cfg_index] = coef_t'(data);
      end
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [DATA_BITS-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %h actual %h", $time, idx, want, prdata);
      err_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    reg_check(REG_NUM_STAGES, DATA_BITS'(cfg_stages));
    reg_check(REG_COEF_INDEX, DATA_BITS'(cfg_index));
    reg_check(REG_COEF_VALUE, cfg_value);
  endtask

  // out-of-range index and unknown register: table must stay put
  task automatic poke_spares();
    logic [DATA_BITS-1:0] spare_idx;
    if ($urandom_range(0, 1)) begin
      reg_write(REG_COEF_INDEX, DATA_BITS'(CIDX_BITS'('1)));
      reg_write(REG_COEF_VALUE, Q_MAX);
    end else begin
      spare_idx = ($urandom & ~DATA_BITS'(CIDX_BITS'('1))) |
                  DATA_BITS'($urandom_range(NUM_COEFS, 31));
      reg_write(REG_COEF_INDEX, spare_idx);
      reg_write(REG_COEF_VALUE, $urandom);
    end
    reg_write(REG_UNUSED, $urandom);
    check_regs();
  endtask

  task automatic load_coefs(input coef_set_e cset);
    coef_t c [COEFS_PER_STAGE];
    longint a1, a2, lim;
    for (int k = 0; k < MAX_STAGES; k++) begin
      case (cset)
        SET_UNITY:   c = '{Q_ONE, 0, 0, 0, 0};
        SET_NEG2: begin
          // only the first section carries the gain of -2.0
          c = '{Q_ONE, 0, 0, 0, 0};
          if (k == 0) c[C_B0] = Q_MIN;
        end
        SET_LOWPASS: c = '{LP_B0, LP_B1, LP_B0, LP_A1, LP_A2};
        SET_STABLE: begin
          // keep poles inside the stability triangle
          a2  = longint'($urandom_range(0, 2 * A2_LIM)) - A2_LIM;
          lim = (UNITY + a2) * 9 / 10;
          a1  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
          for (int j = 0; j < 3; j++) begin
            c[j] = coef_t'(longint'($urandom_range(0, 2 * UNITY)) - UNITY);
          end
          c[C_A1] = coef_t'(a1);
          c[C_A2] = coef_t'(a2);
        end
        default: begin
          for (int j = 0; j < COEFS_PER_STAGE; j++) c[j] = coef_t'($urandom);
        end
      endcase
      for (int j = 0; j < COEFS_PER_STAGE; j++) begin
        reg_write(REG_COEF_INDEX, DATA_BITS'(k * COEFS_PER_STAGE + j));
        reg_write(REG_COEF_VALUE, c[j]);
      end
    end
  endtask

  task automatic stop_sending();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    stop_sending();
    while (out_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_item(input sample_t x, input logic eob, input logic known,
                           input sample_t want);
    filtered_t res;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_sample    <= x;
    end_of_block <= eob;
    do @(posedge clk); while (!in_ready);
    res.smp = filter_sample(x);
    if (known) res.smp = want;
    res.eob = eob;
    out_expect.push_back(res);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 60);
    end
  endtask

  task automatic shuffle_setup();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: load_coefs(SET_STABLE);
      6: load_coefs(SET_WILD);
      7: load_coefs(SET_LOWPASS);
      8: load_coefs(SET_UNITY);
      default: begin
        // nudge a few entries of the current table
        repeat ($urandom_range(1, 3)) begin
          reg_write(REG_COEF_INDEX, DATA_BITS'($urandom_range(0, NUM_COEFS - 1)));
          reg_write(REG_COEF_VALUE, DATA_BITS'(int'($urandom_range(0, 1 << 29)) - (1 << 28)));
        end
      end
    endcase
    case ($urandom_range(0, 9))
      0:       reg_write(REG_NUM_STAGES, '0);
      1, 2:    reg_write(REG_NUM_STAGES, DATA_BITS'(1));
      3, 4:    reg_write(REG_NUM_STAGES, DATA_BITS'(2));
      5:       reg_write(REG_NUM_STAGES, DATA_BITS'(3));
      6, 7:    reg_write(REG_NUM_STAGES, DATA_BITS'(MAX_STAGES));
      8:       reg_write(REG_NUM_STAGES, DATA_BITS'($urandom_range(MAX_STAGES + 1, 7)));
      default: reg_write(REG_NUM_STAGES, $urandom);
    endcase
    poke_spares();
  endtask

  // output side stalls: switch at random among open, coin-flip, fixed comb and choked modes
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_COMB:  out_ready <= (rx_tick % 7) < 3;
      default:  out_ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  always @(posedge clk) begin : check_out
    filtered_t want;
    if (!rst && out_valid && out_ready) begin
      if (out_expect.size() == 0) begin
        $display("%0t: unexpected item, actual out_sample %0d end_of_block_out %b",
                 $time, out_sample, end_of_block_out);
        err_count++;
      end else begin
        want = out_expect.pop_front();
        if (out_sample !== want.smp) begin
          $display("%0t: out_sample expected %0d actual %0d", $time, want.smp, out_sample);
          err_count++;
        end
        if (end_of_block_out !== want.eob) begin
          $display("%0t: end_of_block_out expected %b actual %b",
                   $time, want.eob, end_of_block_out);
          err_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("** cascaded_biquad_iir_filter: FAILED **");
    $finish;
  end

  initial begin
    dir_row_t row;
    coef_set_e cur_set;
    logic [2:0] cur_stages;
    logic loaded;
    int rand_sent;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    in_sample    = '0;
    end_of_block = 1'b0;
    loaded       = 1'b0;
    cur_set      = SET_UNITY;
    cur_stages   = '0;
    rand_sent    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_regs();

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (!loaded || row.cset != cur_set || row.stages != cur_stages) begin
        wait_idle();
        if (!loaded || row.cset != cur_set) load_coefs(row.cset);
        reg_write(REG_NUM_STAGES, DATA_BITS'(row.stages));
        poke_spares();
        loaded     = 1'b1;
        cur_set    = row.cset;
        cur_stages = row.stages;
      end
      send_item(row.smp, row.eob, row.known, row.want);
    end

    while (rand_sent < RAND_ITEMS) begin
      wait_idle();
      shuffle_setup();
      repeat ($urandom_range(60, 200)) begin
        send_item(pick_sample(), $urandom_range(0, 7) == 0, 1'b0, '0);
        rand_sent++;
      end
    end

    stop_sending();
    while (out_expect.size() != 0) @(posedge clk);
    repeat (4 * MAX_STAGES + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("** cascaded_biquad_iir_filter: PASSED **");
    end else begin
      $display("** cascaded_biquad_iir_filter: FAILED **");
    end
    $finish;
  end

endmodule
